[rtl/tsrr_pkg.sv]
// Shared types and constants for the task slot round-robin scheduler.
package tsrr_pkg;

    // Operation codes carried in the func field
    typedef enum logic [1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_RUN    = 2'd1,
        FUNC_SWITCH = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_FREE = 2'd1,
        STAT_FULL    = 2'd2
    } t_status;

    // Operation on the slot status table for one accepted word
    typedef struct packed {
        logic alloc;   // claim the lowest free slot
        logic mark;    // mark the given slot active
    } t_slot_op;

    localparam int unsigned   FTD_W     = 13;
    localparam logic [12:0]   FTD_RESET = 13'd3;
    localparam int unsigned   SEL_SHIFT = 3;   // selector = descriptor index times 8

endpackage

[rtl/tsrr_slot_table.sv]
// Free/busy table of task slots with a lowest-free-slot finder.
module tsrr_slot_table
    import tsrr_pkg::*;
#(
    parameter int unsigned TASK_SLOTS = 16,
    parameter int unsigned SW         = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_slot_op      i_op,
    input  logic [SW-1:0] i_mark_slot,
    output logic          o_found,
    output logic [SW-1:0] o_free_slot
);

    // Only free versus taken is ever observed, so one bit per slot is kept
    logic [TASK_SLOTS-1:0] r_free;
    logic [TASK_SLOTS-1:0] n_free;

    // Find the lowest free slot
    always_comb begin
        o_found     = 1'b0;
        o_free_slot = '0;
        for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                o_found     = 1'b1;
                o_free_slot = SW'(i);
            end
        end
    end

    // Clear the claimed or activated slot
    always_comb begin
        n_free = r_free;
        if (i_op.alloc && o_found) begin
            n_free[o_free_slot] = 1'b0;
        end
        if (i_op.mark) begin
            n_free[i_mark_slot] = 1'b0;
        end
    end

    // Slot 0 starts taken, every other slot free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= {{(TASK_SLOTS-1){1'b1}}, 1'b0};
        end else begin
            r_free <= n_free;
        end
    end

endmodule

[rtl/task_slot_round_robin_scheduler.sv]
// Top level of the task slot round-robin scheduler.
//
//  channel   signals                               direction  accepted when
//  -------   -------------------------------       ---------  --------------------
//  command   start, busy, i_func, i_slot_in        in/out     start && !busy
//  result    o_done, o_status, o_slot_out,         out        every cycle o_done is high
//            o_selector, o_ready_total
//  config    i_cfg_valid, o_cfg_ready, i_cfg_data  in/out     i_cfg_valid && o_cfg_ready
//
// One command word is taken every cycle; busy stays low. Its result appears on
// the cycle after acceptance, for one cycle, set by the registered read of the
// ready list memory. Synchronous reset leaves slot 0 active and the only ready
// entry, count 1, position 0, descriptor base 3. The receiver cannot stall, so
// results are never held back.
module task_slot_round_robin_scheduler
    import tsrr_pkg::*;
#(
    parameter int unsigned TASK_SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_func,
    input  logic [3:0]       i_slot_in,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [3:0]       o_slot_out,
    output logic [15:0]      o_selector,
    output logic [4:0]       o_ready_total,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [FTD_W-1:0] i_cfg_data
);

    localparam int unsigned SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int unsigned CW = $clog2(TASK_SLOTS + 1);

    // Control state
    logic [FTD_W-1:0] r_ftd;
    logic [CW-1:0]    r_count, n_count;
    logic [SW-1:0]    r_pos, n_pos;
    logic             r_done;

    // Result register
    t_status          r_status, n_status;
    logic [SW-1:0]    r_slot, n_slot;
    logic             r_slot_valid, n_slot_valid;
    logic             r_from_list, n_from_list;
    logic             r_rd_zero;
    logic [4:0]       r_total;

    // Ready list memory
    logic [SW-1:0]    r_list [TASK_SLOTS];
    logic [SW-1:0]    r_rd_data;
    logic [SW-1:0]    rd_addr;
    logic             wr_en;

    logic             accept;
    t_func            func;
    logic [SW-1:0]    slot_mod;
    logic             full;
    logic [SW-1:0]    pos_inc;
    t_slot_op         slot_op;
    logic             found;
    logic [SW-1:0]    free_slot;
    logic [SW-1:0]    slot_sel;
    logic [15:0]      slot16;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign func        = t_func'(i_func);
    assign full        = (r_count == CW'(TASK_SLOTS));
    assign pos_inc     = r_pos + SW'(1);

    // Reduce the slot index modulo the slot count
    always_comb begin
        slot_mod = '0;
        for (int v = 0; v < 16; v++) begin
            if (i_slot_in == 4'(v)) begin
                slot_mod = SW'(v % TASK_SLOTS);
            end
        end
    end

    // Decide state updates and the result for the accepted word
    always_comb begin
        n_count      = r_count;
        n_pos        = r_pos;
        n_status     = STAT_OK;
        n_slot       = '0;
        n_slot_valid = 1'b1;
        n_from_list  = 1'b0;
        slot_op      = '0;
        wr_en        = 1'b0;
        rd_addr      = r_pos;
        unique case (func)
            FUNC_ALLOC: begin
                slot_op.alloc = accept;
                n_slot        = free_slot;
                n_slot_valid  = found;
                n_status      = found ? STAT_OK : STAT_NO_FREE;
            end
            FUNC_RUN: begin
                n_slot = slot_mod;
                if (full) begin
                    n_status = STAT_FULL;
                end else begin
                    slot_op.mark = accept;
                    wr_en        = accept;
                    n_count      = r_count + CW'(1);
                end
            end
            FUNC_SWITCH: begin
                n_from_list = 1'b1;
                if (r_count >= CW'(2)) begin
                    n_pos = (CW'(pos_inc) == r_count || pos_inc == '0) ? '0 : pos_inc;
                end
                rd_addr = n_pos;
            end
            FUNC_NOP: begin
                n_from_list = 1'b1;
            end
            default: begin
                n_from_list = 1'b1;
            end
        endcase
    end

    tsrr_slot_table #(
        .TASK_SLOTS (TASK_SLOTS),
        .SW         (SW)
    ) u_slot_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (slot_op),
        .i_mark_slot (slot_mod),
        .o_found     (found),
        .o_free_slot (free_slot)
    );

    // Append to the ready list and read the selected entry
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_list[r_count[SW-1:0]] <= slot_mod;
        end
        r_rd_data <= r_list[rd_addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ftd   <= FTD_RESET;
            r_count <= CW'(1);
            r_pos   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= accept;
            if (i_cfg_valid && o_cfg_ready) begin
                r_ftd <= i_cfg_data;
            end
            if (accept) begin
                r_count <= n_count;
                r_pos   <= n_pos;
            end
        end
    end

    // Hold the result word; entry 0 of the list is never written and reads as 0
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status     <= n_status;
            r_slot       <= n_slot;
            r_slot_valid <= n_slot_valid;
            r_from_list  <= n_from_list;
            r_rd_zero    <= (rd_addr == '0);
            r_total      <= 5'(n_count);
        end
    end

    // Drive the result ports
    always_comb begin
        if (r_from_list) begin
            slot_sel = r_rd_zero ? '0 : r_rd_data;
        end else begin
            slot_sel = r_slot;
        end
        slot16 = 16'(slot_sel);
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_slot_out    = r_slot_valid ? slot16[3:0] : 4'd0;
    assign o_selector    = r_slot_valid ? 16'((16'(r_ftd) + slot16) << SEL_SHIFT) : 16'd0;
    assign o_ready_total = r_total;

endmodule
